/* rtl/core/dns_message_field_parser_unit_defines.svh */
// ---------------------------------------------------------------------------
// dns_message_field_parser_unit_defines.svh
// Assertion macros shared by the parser checker.
// ---------------------------------------------------------------------------
`ifndef DNS_MESSAGE_FIELD_PARSER_UNIT_DEFINES_SVH
`define DNS_MESSAGE_FIELD_PARSER_UNIT_DEFINES_SVH

// Clocked assertion, off while reset is high
`define DMFP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("dmfp checker: property failed");

// Clocked assertion, also live during reset
`define DMFP_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("dmfp checker: property failed");

`endif

/* rtl/core/dmfp_pkg.sv */
// ---------------------------------------------------------------------------
// dmfp_pkg
// Beat types, parse phases, result kinds and phase tables for the parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dmfp_pkg;

  // One message byte per input beat
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } byte_beat_t;

  // One parsed field per output beat
  typedef struct packed {
    logic [4:0]  field_kind;
    logic [31:0] field_value;
    logic        message_done;
  } field_beat_t;

  typedef enum logic [4:0] {
    PH_ID     = 5'd0,
    PH_FLAGS  = 5'd1,
    PH_QDCNT  = 5'd2,
    PH_ANCNT  = 5'd3,
    PH_NSCNT  = 5'd4,
    PH_ARCNT  = 5'd5,
    PH_QNAME  = 5'd6,
    PH_QTYPE  = 5'd7,
    PH_QCLASS = 5'd8,
    PH_ASTART = 5'd9,
    PH_ANAME  = 5'd10,
    PH_PTR    = 5'd11,
    PH_TYPE   = 5'd12,
    PH_CLASS  = 5'd13,
    PH_TTL    = 5'd14,
    PH_RDLEN  = 5'd15,
    PH_RDATA  = 5'd16,
    PH_EXTRA  = 5'd17
  } phase_t;

  typedef enum logic [4:0] {
    KIND_ID         = 5'd0,
    KIND_FLAGS      = 5'd1,
    KIND_QDCOUNT    = 5'd2,
    KIND_ANCOUNT    = 5'd3,
    KIND_NSCOUNT    = 5'd4,
    KIND_ARCOUNT    = 5'd5,
    KIND_QNAME_CHAR = 5'd6,
    KIND_QNAME_END  = 5'd7,
    KIND_QTYPE      = 5'd8,
    KIND_QCLASS     = 5'd9,
    KIND_ANAME_CHAR = 5'd10,
    KIND_ANAME_END  = 5'd11,
    KIND_NAME_REUSE = 5'd12,
    KIND_TYPE       = 5'd13,
    KIND_CLASS      = 5'd14,
    KIND_TTL        = 5'd15,
    KIND_RDLENGTH   = 5'd16,
    KIND_RDATA      = 5'd17,
    KIND_EXTRA      = 5'd18,
    KIND_TRUNCATED  = 5'd19,
    KIND_NAME_LONG  = 5'd20
  } kind_t;

  // Parser state carried from beat to beat
  typedef struct packed {
    phase_t      phase;
    logic [2:0]  field_byte_count;
    logic [31:0] accumulator;
    logic [7:0]  name_length;
    logic [5:0]  label_remaining;
    logic        first_label_done;
    logic [15:0] rdata_remaining;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase:            PH_ID,
    field_byte_count: 3'd0,
    accumulator:      32'd0,
    name_length:      8'd0,
    label_remaining:  6'd0,
    first_label_done: 1'b0,
    rdata_remaining:  16'd0
  };

  localparam logic [7:0]  ROOT_LABEL = 8'd0;
  localparam logic [31:0] DOT_CHAR   = 32'd46;
  localparam logic [1:0]  PTR_TAG    = 2'b11;

  // Byte length of a fixed-size field, zero for variable phases
  function automatic logic [2:0] fixed_len(phase_t ph);
    logic [2:0] len;
    len = 3'd0;
    case (ph)
      PH_ID, PH_FLAGS, PH_QDCNT, PH_ANCNT, PH_NSCNT, PH_ARCNT,
      PH_QTYPE, PH_QCLASS, PH_PTR, PH_TYPE, PH_CLASS, PH_RDLEN: len = 3'd2;
      PH_TTL:  len = 3'd4;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  // Result kind of a fixed-size field
  function automatic kind_t fixed_kind(phase_t ph);
    kind_t k;
    k = KIND_EXTRA;
    case (ph)
      PH_ID:     k = KIND_ID;
      PH_FLAGS:  k = KIND_FLAGS;
      PH_QDCNT:  k = KIND_QDCOUNT;
      PH_ANCNT:  k = KIND_ANCOUNT;
      PH_NSCNT:  k = KIND_NSCOUNT;
      PH_ARCNT:  k = KIND_ARCOUNT;
      PH_QTYPE:  k = KIND_QTYPE;
      PH_QCLASS: k = KIND_QCLASS;
      PH_PTR:    k = KIND_NAME_REUSE;
      PH_TYPE:   k = KIND_TYPE;
      PH_CLASS:  k = KIND_CLASS;
      PH_TTL:    k = KIND_TTL;
      PH_RDLEN:  k = KIND_RDLENGTH;
      default:   k = KIND_EXTRA;
    endcase
    return k;
  endfunction

  // Phase that follows a completed fixed-size field
  function automatic phase_t fixed_next(phase_t ph);
    phase_t n;
    n = PH_EXTRA;
    case (ph)
      PH_ID:     n = PH_FLAGS;
      PH_FLAGS:  n = PH_QDCNT;
      PH_QDCNT:  n = PH_ANCNT;
      PH_ANCNT:  n = PH_NSCNT;
      PH_NSCNT:  n = PH_ARCNT;
      PH_ARCNT:  n = PH_QNAME;
      PH_QTYPE:  n = PH_QCLASS;
      PH_QCLASS: n = PH_ASTART;
      PH_PTR:    n = PH_TYPE;
      PH_TYPE:   n = PH_CLASS;
      PH_CLASS:  n = PH_TTL;
      PH_TTL:    n = PH_RDLEN;
      default:   n = PH_EXTRA;
    endcase
    return n;
  endfunction

endpackage

/* rtl/core/dmfp_in_stage.sv */
// ---------------------------------------------------------------------------
// dmfp_in_stage
// Input register: captures one message byte and offers it to the parse step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmfp_in_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  dmfp_pkg::byte_beat_t byte_beat,
  input  logic                advance,
  output logic                held_valid,
  output dmfp_pkg::byte_beat_t held_beat
);

  // Take a new beat when empty or when the held one moves on this cycle
  assign byte_ready = !held_valid || advance;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      held_valid <= 1'b1;
    end else if (advance) begin
      held_valid <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      held_beat <= byte_beat;
    end
  end

endmodule

/* rtl/core/dmfp_step.sv */
// ---------------------------------------------------------------------------
// dmfp_step
// Parse state and the per-byte step: phase update, field accumulate, name
// decode, and the result of each byte.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmfp_step #(
  parameter int MAX_NAME_BYTES = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  dmfp_pkg::byte_beat_t  cur_beat,
  output logic                  has_result,
  output dmfp_pkg::field_beat_t result
);

  localparam logic [8:0] MaxLen = 9'(MAX_NAME_BYTES);

  dmfp_pkg::parse_state_t state;
  dmfp_pkg::parse_state_t state_next;
  dmfp_pkg::phase_t       phase_step;

  logic [7:0]  b;
  logic        eom;
  logic [2:0]  flen;
  logic [2:0]  cnt_inc;
  logic [31:0] acc_shift;
  logic        fix_done;
  logic        is_ptr;
  logic [8:0]  len_inc;
  logic        too_long;
  logic        in_label;
  logic        is_end;
  logic        in_qname;

  // Decode helpers shared by the next-state and output blocks
  always_comb begin
    b         = cur_beat.data_byte;
    eom       = cur_beat.end_of_message;
    flen      = dmfp_pkg::fixed_len(state.phase);
    cnt_inc   = state.field_byte_count + 3'd1;
    acc_shift = {state.accumulator[23:0], b};
    fix_done  = (flen != 3'd0) && (cnt_inc >= flen);
    is_ptr    = (b[7:6] == dmfp_pkg::PTR_TAG);
    len_inc   = {1'b0, state.name_length} + 9'd1;
    too_long  = len_inc > MaxLen;
    in_label  = state.label_remaining != 6'd0;
    is_end    = b == dmfp_pkg::ROOT_LABEL;
    in_qname  = state.phase == dmfp_pkg::PH_QNAME;
  end

  // Next state
  always_comb begin
    dmfp_pkg::parse_state_t s;
    dmfp_pkg::phase_t       name_done_ph;
    s            = state;
    name_done_ph = in_qname ? dmfp_pkg::PH_QTYPE : dmfp_pkg::PH_TYPE;
    unique case (state.phase)
      dmfp_pkg::PH_ID, dmfp_pkg::PH_FLAGS, dmfp_pkg::PH_QDCNT, dmfp_pkg::PH_ANCNT,
      dmfp_pkg::PH_NSCNT, dmfp_pkg::PH_ARCNT, dmfp_pkg::PH_QTYPE, dmfp_pkg::PH_QCLASS,
      dmfp_pkg::PH_PTR, dmfp_pkg::PH_TYPE, dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL,
      dmfp_pkg::PH_RDLEN: begin
        s.accumulator      = acc_shift;
        s.field_byte_count = cnt_inc;
        if (fix_done) begin
          s.accumulator      = 32'd0;
          s.field_byte_count = 3'd0;
          s.phase            = dmfp_pkg::fixed_next(state.phase);
          if (state.phase == dmfp_pkg::PH_RDLEN) begin
            s.rdata_remaining = acc_shift[15:0];
            s.phase = (acc_shift[15:0] != 16'd0) ? dmfp_pkg::PH_RDATA : dmfp_pkg::PH_EXTRA;
          end
        end
      end
      dmfp_pkg::PH_QNAME, dmfp_pkg::PH_ANAME, dmfp_pkg::PH_ASTART: begin
        if (state.phase == dmfp_pkg::PH_ASTART && is_ptr) begin
          // Compression pointer: first byte starts the two-byte offset
          s.accumulator      = {24'd0, b};
          s.field_byte_count = 3'd1;
          s.phase            = dmfp_pkg::PH_PTR;
        end else begin
          if (state.phase == dmfp_pkg::PH_ASTART) begin
            s.phase = dmfp_pkg::PH_ANAME;
          end
          if (too_long) begin
            s.phase            = dmfp_pkg::PH_EXTRA;
            s.name_length      = 8'd0;
            s.label_remaining  = 6'd0;
            s.first_label_done = 1'b0;
          end else begin
            s.name_length = len_inc[7:0];
            if (in_label) begin
              s.label_remaining = state.label_remaining - 6'd1;
            end else if (is_end) begin
              s.phase            = name_done_ph;
              s.name_length      = 8'd0;
              s.label_remaining  = 6'd0;
              s.first_label_done = 1'b0;
            end else begin
              s.label_remaining  = b[5:0];
              s.first_label_done = 1'b1;
            end
          end
        end
      end
      dmfp_pkg::PH_RDATA: begin
        if (state.rdata_remaining <= 16'd1) begin
          s.rdata_remaining = 16'd0;
          s.phase           = dmfp_pkg::PH_EXTRA;
        end else begin
          s.rdata_remaining = state.rdata_remaining - 16'd1;
        end
      end
      default: begin
        s = state;
      end
    endcase
    phase_step = s.phase;
    // Return to the header at the end of a message
    state_next = eom ? dmfp_pkg::STATE_RESET : s;
  end

  // Result of the byte
  always_comb begin
    dmfp_pkg::kind_t k;
    logic [31:0]     v;
    logic            hit;
    k   = dmfp_pkg::KIND_EXTRA;
    v   = 32'd0;
    hit = 1'b0;
    unique case (state.phase)
      dmfp_pkg::PH_ID, dmfp_pkg::PH_FLAGS, dmfp_pkg::PH_QDCNT, dmfp_pkg::PH_ANCNT,
      dmfp_pkg::PH_NSCNT, dmfp_pkg::PH_ARCNT, dmfp_pkg::PH_QTYPE, dmfp_pkg::PH_QCLASS,
      dmfp_pkg::PH_PTR, dmfp_pkg::PH_TYPE, dmfp_pkg::PH_CLASS, dmfp_pkg::PH_TTL,
      dmfp_pkg::PH_RDLEN: begin
        hit = fix_done;
        k   = dmfp_pkg::fixed_kind(state.phase);
        v   = (state.phase == dmfp_pkg::PH_PTR) ? {18'd0, acc_shift[13:0]} : acc_shift;
      end
      dmfp_pkg::PH_QNAME, dmfp_pkg::PH_ANAME, dmfp_pkg::PH_ASTART: begin
        if (!(state.phase == dmfp_pkg::PH_ASTART && is_ptr)) begin
          if (too_long) begin
            hit = 1'b1;
            k   = dmfp_pkg::KIND_NAME_LONG;
            v   = 32'(MAX_NAME_BYTES);
          end else if (in_label) begin
            hit = 1'b1;
            k   = in_qname ? dmfp_pkg::KIND_QNAME_CHAR : dmfp_pkg::KIND_ANAME_CHAR;
            v   = {24'd0, b};
          end else if (is_end) begin
            hit = 1'b1;
            k   = in_qname ? dmfp_pkg::KIND_QNAME_END : dmfp_pkg::KIND_ANAME_END;
            v   = {23'd0, len_inc};
          end else if (state.first_label_done) begin
            // Label length between labels shows as a dot
            hit = 1'b1;
            k   = in_qname ? dmfp_pkg::KIND_QNAME_CHAR : dmfp_pkg::KIND_ANAME_CHAR;
            v   = dmfp_pkg::DOT_CHAR;
          end
        end
      end
      dmfp_pkg::PH_RDATA: begin
        hit = 1'b1;
        k   = dmfp_pkg::KIND_RDATA;
        v   = {24'd0, b};
      end
      default: begin
        hit = 1'b1;
        k   = dmfp_pkg::KIND_EXTRA;
        v   = {24'd0, b};
      end
    endcase
    // Last byte: always report, and flag a message cut short in the header, question or answer
    if (eom) begin
      hit = 1'b1;
      if (phase_step != dmfp_pkg::PH_ASTART && phase_step != dmfp_pkg::PH_EXTRA) begin
        k = dmfp_pkg::KIND_TRUNCATED;
        v = 32'd0;
      end
    end
    has_result          = hit;
    result.field_kind   = k;
    result.field_value  = v;
    result.message_done = eom;
  end

  // Advance the parse state on each consumed byte
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dmfp_pkg::STATE_RESET;
    end else if (advance) begin
      state <= state_next;
    end
  end

endmodule

/* rtl/core/dmfp_out_stage.sv */
// ---------------------------------------------------------------------------
// dmfp_out_stage
// Result register: holds one parsed field until the consumer takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dmfp_out_stage (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  dmfp_pkg::field_beat_t load_beat,
  output logic                  field_valid,
  input  logic                  field_ready,
  output dmfp_pkg::field_beat_t field_beat,
  output logic                  space
);

  // Room for a new result when empty or draining this cycle
  assign space = !field_valid || field_ready;

  // Track occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      field_valid <= 1'b0;
    end else if (load) begin
      field_valid <= 1'b1;
    end else if (field_ready) begin
      field_valid <= 1'b0;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (load) begin
      field_beat <= load_beat;
    end
  end

endmodule

/* rtl/core/dns_message_field_parser_unit.sv */
// ---------------------------------------------------------------------------
// dns_message_field_parser_unit
// Byte-serial DNS message parser: header, question and one answer record,
// one parsed field per result beat.
//
//   Channel  Direction  Handshake                 Beat
//   byte     in         byte_valid / byte_ready   data_byte, end_of_message
//   field    out        field_valid / field_ready field_kind, field_value,
//                                                 message_done
//
// Each byte passes from the input beat into the input register, then
// through the parse step into the result register.
// One byte is consumed per cycle while the result register can drain.
// A held result stalls the parse step; the input register still takes a
// beat when it is empty.
// Reset is synchronous and returns the parser to the header id field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dns_message_field_parser_unit #(
  parameter int MAX_NAME_BYTES = 255
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  byte_valid,
  output logic                  byte_ready,
  input  dmfp_pkg::byte_beat_t  byte_beat,
  output logic                  field_valid,
  input  logic                  field_ready,
  output dmfp_pkg::field_beat_t field_beat
);

  logic                  held_valid;
  dmfp_pkg::byte_beat_t  held_beat;
  logic                  advance;
  logic                  has_result;
  dmfp_pkg::field_beat_t step_beat;
  logic                  space;

  // Move the held byte through the step when the result register has room
  assign advance = held_valid && space;

  dmfp_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_beat  (byte_beat),
    .advance    (advance),
    .held_valid (held_valid),
    .held_beat  (held_beat)
  );

  dmfp_step #(
    .MAX_NAME_BYTES (MAX_NAME_BYTES)
  ) u_step (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .cur_beat   (held_beat),
    .has_result (has_result),
    .result     (step_beat)
  );

  dmfp_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && has_result),
    .load_beat   (step_beat),
    .field_valid (field_valid),
    .field_ready (field_ready),
    .field_beat  (field_beat),
    .space       (space)
  );

endmodule

/* rtl/core/dmfp_checker.sv */
// ---------------------------------------------------------------------------
// dmfp_checker
// Port-level checks on the parser's result channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dns_message_field_parser_unit_defines.svh"

module dmfp_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  byte_valid,
  input logic                  byte_ready,
  input dmfp_pkg::byte_beat_t  byte_beat,
  input logic                  field_valid,
  input logic                  field_ready,
  input dmfp_pkg::field_beat_t field_beat
);

  // A stalled result holds its payload
  `DMFP_ASSERT(a_out_hold, field_valid && !field_ready |=> field_valid && $stable(field_beat))

  // No result right after reset
  `DMFP_ASSERT_ALWAYS(a_reset_empty, rst |=> !field_valid)

  // Kinds stay within the defined range
  `DMFP_ASSERT(a_kind_range, field_valid |-> field_beat.field_kind <= dmfp_pkg::KIND_NAME_LONG)

  // A truncation report always closes the message
  `DMFP_ASSERT(a_trunc_done,
    field_valid && field_beat.field_kind == dmfp_pkg::KIND_TRUNCATED |-> field_beat.message_done)

  // Last byte of a message yields a closing result once the result register has room
  `DMFP_ASSERT(a_eom_result,
    byte_valid && byte_ready && byte_beat.end_of_message ##1 (!field_valid || field_ready)
    |=> field_valid && field_beat.message_done)

endmodule

bind dns_message_field_parser_unit dmfp_checker u_dmfp_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_ready  (byte_ready),
  .byte_beat   (byte_beat),
  .field_valid (field_valid),
  .field_ready (field_ready),
  .field_beat  (field_beat)
);

/* tb/sv/dmfp_tb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmfp_tb_pkg
// Field tracker for the DNS message parser bench: mirrors the parse state
// byte by byte, queues the field each accepted byte should produce and
// matches result beats against that queue in order.
// ---------------------------------------------------------------------------

package dmfp_tb_pkg;

  import dmfp_pkg::*;

  // Longest wire name the bench builds the parser for
  localparam int NAME_LIMIT = 255;

  class dns_field_tracker;

    phase_t      phase;
    logic [2:0]  byte_count;
    logic [31:0] acc;
    logic [7:0]  name_len;
    logic [5:0]  label_left;
    logic        first_label_seen;
    logic [15:0] rdata_left;

    field_beat_t expected_fields[$];
    int unsigned mismatches;

    function new();
      clear_state();
      mismatches = 0;
    endfunction

    function void clear_name();
      name_len = 8'd0;
      label_left = 6'd0;
      first_label_seen = 1'b0;
    endfunction

    function void clear_state();
      phase = PH_ID;
      byte_count = 3'd0;
      acc = 32'd0;
      rdata_left = 16'd0;
      clear_name();
    endfunction

    function int pending();
      return expected_fields.size();
    endfunction

    // Look up size, kind and successor of a fixed-width field; size 0 marks
    // a variable-length phase
    function void fixed_field(input phase_t ph, output logic [2:0] len,
                              output kind_t kind, output phase_t nxt);
      len = 3'd2;
      kind = KIND_EXTRA;
      nxt = PH_EXTRA;
      case (ph)
        PH_ID: begin kind = KIND_ID; nxt = PH_FLAGS; end
        PH_FLAGS: begin kind = KIND_FLAGS; nxt = PH_QDCNT; end
        PH_QDCNT: begin kind = KIND_QDCOUNT; nxt = PH_ANCNT; end
        PH_ANCNT: begin kind = KIND_ANCOUNT; nxt = PH_NSCNT; end
        PH_NSCNT: begin kind = KIND_NSCOUNT; nxt = PH_ARCNT; end
        PH_ARCNT: begin kind = KIND_ARCOUNT; nxt = PH_QNAME; end
        PH_QTYPE: begin kind = KIND_QTYPE; nxt = PH_QCLASS; end
        PH_QCLASS: begin kind = KIND_QCLASS; nxt = PH_ASTART; end
        PH_PTR: begin kind = KIND_NAME_REUSE; nxt = PH_TYPE; end
        PH_TYPE: begin kind = KIND_TYPE; nxt = PH_CLASS; end
        PH_CLASS: begin kind = KIND_CLASS; nxt = PH_TTL; end
        PH_TTL: begin len = 3'd4; kind = KIND_TTL; nxt = PH_RDLEN; end
        PH_RDLEN: kind = KIND_RDLENGTH;
        default: len = 3'd0;
      endcase
    endfunction

    // Advance a name by one wire byte; returns 1 when the byte yields a field
    function bit name_step(input logic [7:0] b, input kind_t char_kind,
                           input kind_t end_kind, input phase_t next_ph,
                           output kind_t k, output logic [31:0] v);
      logic [8:0] grown;
      grown = {1'b0, name_len} + 9'd1;
      k = char_kind;
      v = 32'd0;
      // Cut the name off at the bound and pass the rest through
      if (grown > 9'(NAME_LIMIT)) begin
        k = KIND_NAME_LONG;
        v = 32'(NAME_LIMIT);
        phase = PH_EXTRA;
        clear_name();
        return 1'b1;
      end
      name_len = grown[7:0];
      if (label_left != 6'd0) begin
        label_left = label_left - 6'd1;
        v = {24'd0, b};
        return 1'b1;
      end
      if (b == ROOT_LABEL) begin
        k = end_kind;
        v = {23'd0, grown};
        phase = next_ph;
        clear_name();
        return 1'b1;
      end
      // Length byte: only the low six bits count; no dot before the first
      label_left = b[5:0];
      if (first_label_seen) begin
        v = DOT_CHAR;
        return 1'b1;
      end
      first_label_seen = 1'b1;
      return 1'b0;
    endfunction

    // Take one accepted byte and queue the field it should produce
    function void take_byte(input byte_beat_t beat);
      logic [7:0]  b;
      kind_t       k;
      logic [31:0] v;
      bit          made;
      logic [2:0]  flen;
      kind_t       fkind;
      phase_t      fnext;
      field_beat_t want;
      b = beat.data_byte;
      k = KIND_EXTRA;
      v = 32'd0;
      made = 1'b0;
      fixed_field(phase, flen, fkind, fnext);
      if (flen != 3'd0) begin
        // Shift in big-endian and emit when the field is complete
        acc = {acc[23:0], b};
        byte_count = byte_count + 3'd1;
        if (byte_count >= flen) begin
          k = fkind;
          v = (phase == PH_PTR) ? {18'd0, acc[13:0]} : acc;
          made = 1'b1;
          if (phase == PH_RDLEN) begin
            rdata_left = acc[15:0];
            fnext = (rdata_left != 16'd0) ? PH_RDATA : PH_EXTRA;
          end
          acc = 32'd0;
          byte_count = 3'd0;
          phase = fnext;
        end
      end else begin
        case (phase)
          PH_QNAME: made = name_step(b, KIND_QNAME_CHAR, KIND_QNAME_END, PH_QTYPE, k, v);
          PH_ASTART: begin
            if (b[7:6] == PTR_TAG) begin
              acc = {24'd0, b};
              byte_count = 3'd1;
              phase = PH_PTR;
            end else begin
              phase = PH_ANAME;
              made = name_step(b, KIND_ANAME_CHAR, KIND_ANAME_END, PH_TYPE, k, v);
            end
          end
          PH_ANAME: made = name_step(b, KIND_ANAME_CHAR, KIND_ANAME_END, PH_TYPE, k, v);
          PH_RDATA: begin
            k = KIND_RDATA;
            v = {24'd0, b};
            made = 1'b1;
            if (rdata_left <= 16'd1) begin
              rdata_left = 16'd0;
              phase = PH_EXTRA;
            end else begin
              rdata_left = rdata_left - 16'd1;
            end
          end
          default: begin
            k = KIND_EXTRA;
            v = {24'd0, b};
            made = 1'b1;
          end
        endcase
      end
      // Last byte: report truncation unless the message ended cleanly
      if (beat.end_of_message) begin
        if (phase != PH_ASTART && phase != PH_EXTRA) begin
          k = KIND_TRUNCATED;
          v = 32'd0;
        end
        made = 1'b1;
        clear_state();
      end
      if (made) begin
        want.field_kind = k;
        want.field_value = v;
        want.message_done = beat.end_of_message;
        expected_fields.push_back(want);
      end
    endfunction

    // Match one result beat against the oldest queued field
    function void match_field(input field_beat_t got);
      field_beat_t want;
      if (expected_fields.size() == 0) begin
        $error("unexpected field beat: kind %0d value %08h done %0d",
               got.field_kind, got.field_value, got.message_done);
        mismatches++;
        return;
      end
      want = expected_fields.pop_front();
      if (got.field_kind !== want.field_kind) begin
        $error("field_kind: expected %0d, got %0d", want.field_kind, got.field_kind);
        mismatches++;
      end
      if (got.field_value !== want.field_value) begin
        $error("field_value: expected %08h, got %08h", want.field_value, got.field_value);
        mismatches++;
      end
      if (got.message_done !== want.message_done) begin
        $error("message_done: expected %0d, got %0d", want.message_done, got.message_done);
        mismatches++;
      end
    endfunction

  endclass

endpackage

/* tb/sv/tb_dns_message_field_parser_unit.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dns_message_field_parser_unit
// Streams DNS messages into the parser one byte per beat: a few hand-built
// messages, then random well-formed, cut-short, noise and over-long-name
// messages. Both channels idle at random; every result beat is matched
// field by field against the tracker's queue.
// ---------------------------------------------------------------------------

module tb_dns_message_field_parser_unit;

  import dmfp_pkg::*;
  import dmfp_tb_pkg::*;

  localparam int TOTAL_BYTES  = 900;
  localparam int LONG_HOLD    = 300;
  localparam int STALL_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 20;

  typedef enum int {RX_OPEN, RX_COIN, RX_COMB, RX_SPARSE} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        byte_valid;
  logic        byte_ready;
  byte_beat_t  byte_beat;
  logic        field_valid;
  logic        field_ready;
  field_beat_t field_beat;

  dns_field_tracker tracker;
  logic [7:0]       msg_bytes[$];
  bit               hold_off_req;
  bit               steady_sender;
  int               burst_left;
  int               items_sent;
  int               idle_cycles;

  dns_message_field_parser_unit #(
    .MAX_NAME_BYTES(NAME_LIMIT)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_beat   (byte_beat),
    .field_valid (field_valid),
    .field_ready (field_ready),
    .field_beat  (field_beat)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Hold the line idle with junk on the payload
  task automatic idle_for(input int n);
    repeat (n) begin
      @(negedge clk);
      byte_valid <= 1'b0;
      byte_beat <= {8'($urandom), 1'($urandom)};
    end
  endtask

  // Offer one byte in bursts, wait for the handshake, then note it
  task automatic push_byte(input byte_beat_t b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (!steady_sender) idle_for($urandom_range(1, 10));
    end
    burst_left--;
    @(negedge clk);
    byte_valid <= 1'b1;
    byte_beat <= b;
    do @(posedge clk); while (!byte_ready);
    tracker.take_byte(b);
    items_sent++;
  endtask

  task automatic send_message();
    foreach (msg_bytes[i]) push_byte({msg_bytes[i], i == msg_bytes.size() - 1});
  endtask

  // Drop valid and wait until every queued field has come back
  task automatic wait_for_drain();
    @(negedge clk);
    byte_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_random(input int n);
    repeat (n) msg_bytes.push_back(rand_byte());
  endfunction

  // Append a name of the given wire length, terminator included. Length
  // bytes sometimes carry stray top bits; an answer name never starts with
  // the pointer tag
  function automatic void put_name(input int wire_len, input bit in_answer);
    int         left;
    int         l;
    int         top_max;
    logic [1:0] top;
    bit         first;
    left = wire_len - 1;
    first = 1'b1;
    while (left > 0) begin
      l = $urandom_range(0, (left - 1 > 63) ? 63 : left - 1);
      top_max = (in_answer && first) ? 2 : 3;
      if (l == 0 || $urandom_range(0, 3) == 0) top = 2'($urandom_range(1, top_max));
      else top = 2'b00;
      msg_bytes.push_back({top, 6'(l)});
      put_random(l);
      left -= l + 1;
      first = 1'b0;
    end
    msg_bytes.push_back(ROOT_LABEL);
  endfunction

  function automatic int pick_name_len();
    if ($urandom_range(0, 7) == 0) return $urandom_range(64, 90);
    return $urandom_range(1, 20);
  endfunction

  // Build a random message: mostly well formed, some cut short, some noise
  function automatic void build_message();
    int style;
    int rdlen;
    int keep;
    msg_bytes.delete();
    style = $urandom_range(0, 19);
    if (style < 2) begin
      put_random($urandom_range(1, 24));
      return;
    end
    put_random(12);
    put_name(pick_name_len(), 1'b0);
    put_random(4);
    if ($urandom_range(0, 5) != 0) begin
      if ($urandom_range(0, 1) == 1) begin
        msg_bytes.push_back({PTR_TAG, 6'($urandom)});
        msg_bytes.push_back(rand_byte());
      end else begin
        put_name(pick_name_len(), 1'b1);
      end
      put_random(8);
      rdlen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 6);
      msg_bytes.push_back(8'(rdlen >> 8));
      msg_bytes.push_back(8'(rdlen));
      put_random((rdlen > 8) ? 8 : rdlen);
      put_random($urandom_range(0, 3));
    end
    // Cut short at a random byte
    if (style < 5) begin
      keep = $urandom_range(1, msg_bytes.size());
      while (msg_bytes.size() > keep) void'(msg_bytes.pop_back());
    end
  endfunction

  // Build a message whose question or answer name runs to wire_len bytes
  function automatic void build_long(input int wire_len, input bit in_answer);
    msg_bytes.delete();
    put_random(12);
    if (in_answer) begin
      put_name($urandom_range(1, 12), 1'b0);
      put_random(4);
      put_name(wire_len, 1'b1);
    end else begin
      put_name(wire_len, 1'b0);
      put_random(4);
    end
    put_random(10);
  endfunction

  // Check each result beat as it is taken
  always @(posedge clk) begin
    if (!rst && field_valid && field_ready) tracker.match_field(field_beat);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (byte_valid && byte_ready) || (field_valid && field_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_dns_message_field_parser_unit: errors");
      $finish;
    end
  end

  // Result side: switch stall patterns now and then; hold off on request
  initial begin
    rx_mode_t mode;
    int       span;
    int       tick;
    field_ready = 1'b0;
    mode = RX_OPEN;
    span = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        field_ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
      end else begin
        if (span == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          span = $urandom_range(16, 96);
        end
        span--;
        tick++;
        case (mode)
          RX_OPEN: field_ready <= 1'b1;
          RX_COIN: field_ready <= 1'($urandom_range(0, 1));
          RX_COMB: field_ready <= ((tick % 5) < 2);
          default: field_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Stimulus
  initial begin
    tracker = new();
    rst = 1'b1;
    byte_valid = 1'b0;
    byte_beat = '0;
    hold_off_req = 1'b0;
    steady_sender = 1'b0;
    burst_left = 0;
    items_sent = 0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Lone byte: message ends inside the id field
    msg_bytes = '{8'hFF};
    send_message();
    // Extreme header words, a pointer-looking and an empty label in the
    // question, and a message that stops right after the question
    msg_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF,
                  8'h00, 8'h00, 8'hFF, 8'hFF, 8'hC1, 8'hFF, 8'h40, 8'h00,
                  8'h00, 8'h00, 8'hFF, 8'hFF};
    send_message();
    wait_for_drain();

    // Block the result side while bytes keep coming in back to back
    hold_off_req = 1'b1;
    steady_sender = 1'b1;
    msg_bytes.delete();
    put_random(12);
    put_name(16, 1'b0);
    put_random(4);
    send_message();
    steady_sender = 1'b0;
    wait_for_drain();

    // Name at the bound, then one that runs past it
    build_long(NAME_LIMIT, 1'b0);
    send_message();
    build_long($urandom_range(NAME_LIMIT + 1, NAME_LIMIT + 15), 1'b1);
    send_message();

    while (items_sent < TOTAL_BYTES) begin
      if ($urandom_range(0, 39) == 0)
        build_long($urandom_range(NAME_LIMIT - 5, NAME_LIMIT + 15), 1'($urandom_range(0, 1)));
      else
        build_message();
      steady_sender = ($urandom_range(0, 3) == 0);
      send_message();
      if ($urandom_range(0, 15) == 0) wait_for_drain();
    end

    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("tb_dns_message_field_parser_unit: clean");
    end else begin
      $display("tb_dns_message_field_parser_unit: errors");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/dmfp_pkg.sv
rtl/core/dmfp_in_stage.sv
rtl/core/dmfp_step.sv
rtl/core/dmfp_out_stage.sv
rtl/core/dns_message_field_parser_unit.sv
rtl/core/dmfp_checker.sv
tb/sv/dmfp_tb_pkg.sv
tb/sv/tb_dns_message_field_parser_unit.sv
